// ----- sv/tama_pkg.sv -----
`timescale 1ns / 1ps

package tama_pkg;

    // field widths
    localparam int ACCEL_W  = 16;
    localparam int OPCODE_W = 2;
    localparam int OUT_W    = 19;
    localparam int ERR_W    = 16;

    // one g in raw accelerometer counts
    localparam int ONE_G_LSB = 2048;

    // saturation limits of the result fields
    localparam int SUM_OUT_MAX = 262143;
    localparam int SUM_OUT_MIN = -262144;
    localparam int MAG_OUT_MAX = 524287;
    localparam logic [ERR_W-1:0] FAIL_MAX = 16'hFFFF;

    // opcodes of an input word
    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_FAIL   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

// ----- sv/tama_if.sv -----
`timescale 1ns / 1ps

// sample channel
interface tama_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [tama_pkg::OPCODE_W-1:0] opcode;
    logic signed [tama_pkg::ACCEL_W-1:0]  accel_x;
    logic signed [tama_pkg::ACCEL_W-1:0]  accel_y;
    logic signed [tama_pkg::ACCEL_W-1:0]  accel_z;

    modport source (output valid, opcode, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, opcode, accel_x, accel_y, accel_z, output ready);
endinterface

// result channel
interface tama_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tama_pkg::OUT_W-1:0]  filtered_x;
    logic signed [tama_pkg::OUT_W-1:0]  filtered_y;
    logic signed [tama_pkg::OUT_W-1:0]  filtered_z;
    logic        [tama_pkg::OUT_W-1:0]  magnitude;
    logic        [tama_pkg::ERR_W-1:0]  error_count;
    logic                               last_ok;

    modport source (output valid, filtered_x, filtered_y, filtered_z, magnitude,
                    error_count, last_ok, input ready);
    modport sink   (input valid, filtered_x, filtered_y, filtered_z, magnitude,
                    error_count, last_ok, output ready);
endinterface

// ----- sv/three_axis_moving_average_magnitude.sv -----
`timescale 1ns / 1ps

// Three-axis moving average with vector magnitude.
// sample (sink): one word per accelerometer event. opcode 0 is a good sample
// with accel_x/y/z, 1 a sensor read failure, 2 clears the error count.
// result (source): exactly one word per sample word, carrying the three
// window sums, the held magnitude, the error count and the last-ok flag.
// A good sample is worked through the ring memory read, a shared squarer
// used for each axis in turn and a square root that resolves one bit per
// cycle. One word is in work at a time, so a new word is taken the cycle
// after the previous one has reached the output register.
// The output register holds a finished word while the receiver stalls and
// the next word may be accepted and worked on meanwhile.
// Reset: the rings read as zero (entries not yet written since reset are
// masked by a wrap flag), sums and error count are zero, last_ok is one and
// the magnitude is one g (2048 * WINDOW). No clearing pass is needed.
module three_axis_moving_average_magnitude #(
    parameter int WINDOW = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tama_in_if.sink    sample,
    tama_out_if.source result
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = tama_pkg::ACCEL_W + 1 + $clog2(WINDOW);
    localparam int SQ_W   = 2 * SUM_W;
    localparam int REM_W  = SUM_W + 2;
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int EXT_W  = SUM_W + tama_pkg::OUT_W;
    localparam int ENT_W  = 3 * tama_pkg::ACCEL_W;
    localparam int AW     = tama_pkg::ACCEL_W;
    localparam int OW     = tama_pkg::OUT_W;

    localparam logic signed [EXT_W-1:0] SUM_HI = EXT_W'(tama_pkg::SUM_OUT_MAX);
    localparam logic signed [EXT_W-1:0] SUM_LO = EXT_W'(tama_pkg::SUM_OUT_MIN);
    localparam logic [EXT_W-1:0]        MAG_HI = EXT_W'(tama_pkg::MAG_OUT_MAX);
    localparam logic [SUM_W-1:0]        MAG_RST = SUM_W'(tama_pkg::ONE_G_LSB * WINDOW);

    // ring memory, one entry holds x, y and z
    logic [ENT_W-1:0] ring_mem [WINDOW];
    logic [ENT_W-1:0] rd_data_reg;
    logic             ram_we;
    logic [ENT_W-1:0] ram_wdata;

    // control state
    tama_pkg::state_t        state_reg, state_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    wrapped_reg, wrapped_next;
    logic [1:0]              sq_cnt_reg, sq_cnt_next;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [tama_pkg::ERR_W-1:0] fail_reg, fail_next;
    logic                    ok_reg, ok_next;
    logic                    out_valid_reg, out_valid_next;

    // filter state and datapath
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [SUM_W-1:0] sum_z_reg, sum_z_next;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [ENT_W-1:0]        new_reg, new_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [SQ_W-1:0]         rad_reg, rad_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]        root_reg, root_next;

    // output payload registers
    logic signed [OW-1:0]    fx_reg, fx_next;
    logic signed [OW-1:0]    fy_reg, fy_next;
    logic signed [OW-1:0]    fz_reg, fz_next;
    logic [OW-1:0]           fmag_reg, fmag_next;
    logic [tama_pkg::ERR_W-1:0] ferr_reg, ferr_next;
    logic                    fok_reg, fok_next;

    // combinational helpers
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sel_abs;
    logic [REM_W+1:0]        rem_shift;
    logic [REM_W+1:0]        trial;
    logic [ENT_W-1:0]        old_ent;
    logic signed [EXT_W-1:0] ext_x, ext_y, ext_z;
    logic [EXT_W-1:0]        ext_mag;
    logic                    out_free;

    // memory: registered read of the current slot, write of the new entry
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring_mem[slot_reg];
        if (ram_we)
        begin
            ring_mem[slot_reg] <= ram_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tama_pkg::ST_IDLE;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            sq_cnt_reg    <= '0;
            bit_cnt_reg   <= '0;
            fail_reg      <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            mag_reg       <= MAG_RST;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            wrapped_reg   <= wrapped_next;
            sq_cnt_reg    <= sq_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            fail_reg      <= fail_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_z_reg     <= sum_z_next;
            mag_reg       <= mag_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_reg  <= new_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        fz_reg   <= fz_next;
        fmag_reg <= fmag_next;
        ferr_reg <= ferr_next;
        fok_reg  <= fok_next;
    end

    // shared squarer operand
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sel_sum = sum_x_reg;
            2'd1:    sel_sum = sum_y_reg;
            default: sel_sum = sum_z_reg;
        endcase
        sel_abs = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    end

    // root step and output saturation
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        old_ent   = wrapped_reg ? rd_data_reg : '0;
        ext_x     = EXT_W'(sum_x_reg);
        ext_y     = EXT_W'(sum_y_reg);
        ext_z     = EXT_W'(sum_z_reg);
        ext_mag   = EXT_W'(mag_reg);
        out_free  = !out_valid_reg || result.ready;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        wrapped_next   = wrapped_reg;
        sq_cnt_next    = sq_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        fail_next      = fail_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_z_next     = sum_z_reg;
        mag_next       = mag_reg;
        new_next       = new_reg;
        sq_next        = sq_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        fz_next        = fz_reg;
        fmag_next      = fmag_reg;
        ferr_next      = ferr_reg;
        fok_next       = fok_reg;
        ram_we         = 1'b0;
        ram_wdata      = new_reg;
        sample.ready   = 1'b0;

        // output word taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tama_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    new_next = {sample.accel_z, sample.accel_y, sample.accel_x};
                    case (tama_pkg::opcode_t'(sample.opcode))
                        tama_pkg::OP_SAMPLE:
                        begin
                            state_next = tama_pkg::ST_UPDATE;
                        end
                        tama_pkg::OP_FAIL:
                        begin
                            if (fail_reg != tama_pkg::FAIL_MAX)
                            begin
                                fail_next = fail_reg + 1'b1;
                            end
                            ok_next    = 1'b0;
                            state_next = tama_pkg::ST_DONE;
                        end
                        tama_pkg::OP_CLEAR:
                        begin
                            fail_next  = '0;
                            state_next = tama_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = tama_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // oldest entry is in rd_data_reg: update sums and ring
            tama_pkg::ST_UPDATE:
            begin
                sum_x_next = sum_x_reg + SUM_W'(signed'(new_reg[AW-1:0]))
                           - SUM_W'(signed'(old_ent[AW-1:0]));
                sum_y_next = sum_y_reg + SUM_W'(signed'(new_reg[2*AW-1:AW]))
                           - SUM_W'(signed'(old_ent[2*AW-1:AW]));
                sum_z_next = sum_z_reg + SUM_W'(signed'(new_reg[3*AW-1:2*AW]))
                           - SUM_W'(signed'(old_ent[3*AW-1:2*AW]));
                ram_we = 1'b1;
                if (slot_reg == SLOT_W'(WINDOW - 1))
                begin
                    slot_next    = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                ok_next     = 1'b1;
                sq_cnt_next = '0;
                rad_next    = '0;
                state_next  = tama_pkg::ST_SQUARE;
            end

            // one square per cycle, the x, y and z squares accumulated in the following cycle
            tama_pkg::ST_SQUARE:
            begin
                if (sq_cnt_reg != 2'd0)
                begin
                    rad_next = rad_reg + sq_reg;
                end
                sq_next     = SQ_W'(sel_abs) * SQ_W'(sel_abs);
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 2'd3)
                begin
                    rem_next     = '0;
                    root_next    = '0;
                    bit_cnt_next = CNT_W'(SUM_W - 1);
                    state_next   = tama_pkg::ST_ROOT;
                end
            end

            // digit-by-digit square root, one root bit per cycle
            tama_pkg::ST_ROOT:
            begin
                rad_next = {rad_reg[SQ_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = REM_W'(rem_shift - trial);
                    root_next = {root_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_shift);
                    root_next = {root_reg[SUM_W-2:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    mag_next   = root_next;
                    state_next = tama_pkg::ST_DONE;
                end
            end

            // load the output register once it is free
            tama_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    fx_next = (ext_x > SUM_HI) ? OW'(SUM_HI) :
                              (ext_x < SUM_LO) ? OW'(SUM_LO) : OW'(ext_x);
                    fy_next = (ext_y > SUM_HI) ? OW'(SUM_HI) :
                              (ext_y < SUM_LO) ? OW'(SUM_LO) : OW'(ext_y);
                    fz_next = (ext_z > SUM_HI) ? OW'(SUM_HI) :
                              (ext_z < SUM_LO) ? OW'(SUM_LO) : OW'(ext_z);
                    fmag_next      = (ext_mag > MAG_HI) ? OW'(MAG_HI) : OW'(ext_mag);
                    ferr_next      = fail_reg;
                    fok_next       = ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = tama_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tama_pkg::ST_IDLE;
            end
        endcase
    end

    // result channel
    assign result.valid       = out_valid_reg;
    assign result.filtered_x  = fx_reg;
    assign result.filtered_y  = fy_reg;
    assign result.filtered_z  = fz_reg;
    assign result.magnitude   = fmag_reg;
    assign result.error_count = ferr_reg;
    assign result.last_ok     = fok_reg;

endmodule
